FILE: src/freq_droop_power_setpoint_assert.svh
// Assertion macros for the droop setpoint block.
// Needs signals named clock and reset in the including scope.
`ifndef FREQ_DROOP_POWER_SETPOINT_ASSERT_SVH
`define FREQ_DROOP_POWER_SETPOINT_ASSERT_SVH

// consequent checked in the same cycle
`define FDPS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fdps check failed");

// consequent checked in the next cycle
`define FDPS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fdps check failed");

`endif

FILE: src/fdps_pkg.sv
// Shared widths, constants, register indexes and control types of the droop setpoint block.
// No dependencies.
package fdps_pkg;

   localparam int PWR_W      = 10;
   localparam int FREQ_W     = 17;
   localparam int LVL_W      = 20;
   localparam int SET_W      = 14;
   localparam int BAND_W     = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam int DIFF_W = PWR_W + 1;
   localparam int DF_W   = FREQ_W + 1;
   localparam int PROD_W = 29;
   localparam int BASE_W = 16;
   localparam int FACT_W = LVL_W + 1;
   localparam int NUM_W  = FACT_W + PWR_W;
   localparam int REM_W  = BAND_W;
   localparam int CNT_W  = 5;
   localparam int ACC_W  = 40;
   localparam int RND_W  = 16;

   localparam logic [FREQ_W-1:0] NOMINAL_MHZ = 17'd60000;
   localparam logic [CNT_W-1:0]  DIV_LAST    = CNT_W'(NUM_W - 1);

   // floor(x/10) = (x * DIV10_RECIP) >> DIV10_SHIFT, exact for x < 2^22
   localparam int                DIV10_SHIFT = 23;
   localparam logic [23:0]       DIV10_RECIP = 24'd838861;
   // floor(y/6) = (y * DIV6_RECIP) >> DIV6_SHIFT, exact for y < 2^17
   localparam int                DIV6_SHIFT  = 18;
   localparam logic [16:0]       DIV6_RECIP  = 17'd43691;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_POWER_MIN     = 3'd0,
      REG_POWER_MAX     = 3'd1,
      REG_ALGORITHM_ON  = 3'd2,
      REG_DEADLINE_MODE = 3'd3,
      REG_BUFFER_LENGTH = 3'd4
   } reg_index_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MUL   = 6'b000010,
      S_DIV   = 6'b000100,
      S_SUM   = 6'b001000,
      S_CLAMP = 6'b010000,
      S_FIN   = 6'b100000
   } state_type;

   typedef struct packed {
      logic [PWR_W-1:0]  power_min;
      logic [PWR_W-1:0]  power_max;
      logic              algorithm_on;
      logic              deadline_mode;
      logic [LVL_W-1:0]  buffer_length;
      logic [BAND_W-1:0] band;
      logic              level_load;
      logic [LVL_W-1:0]  level_value;
   } cfg_type;

   typedef struct packed {
      logic take;
      logic mul;
      logic div_step;
      logic sum;
      logic clamp;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic alg_on;
      logic step_en;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

FILE: src/fdps_if.sv
// Handshake channels of the droop setpoint block: request, response, register write.
// Depends on fdps_pkg.
interface fdps_req_if import fdps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [FREQ_W-1:0] frequency_mhz;
   logic [LVL_W-1:0]  frames_buffered;
   modport source (output valid, req_type, frequency_mhz, frames_buffered, input ready);
   modport sink   (input valid, req_type, frequency_mhz, frames_buffered, output ready);
endinterface

interface fdps_rsp_if import fdps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SET_W-1:0]  setpoint_tenths;
   logic [FREQ_W-1:0] frequency_echo;
   logic              setpoint_valid;
   modport source (output valid, setpoint_tenths, frequency_echo, setpoint_valid, input ready);
   modport sink   (input valid, setpoint_tenths, frequency_echo, setpoint_valid, output ready);
endinterface

interface fdps_csr_if import fdps_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: src/fdps_regs.sv
// Configuration registers and slope band (length/10 by reciprocal multiply).
// Depends on fdps_pkg and fdps_csr_if.
module fdps_regs import fdps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   fdps_csr_if.sink   csr_bus,
   output cfg_type    cfg
);

   logic [PWR_W-1:0]  power_min_ff, power_min_in;
   logic [PWR_W-1:0]  power_max_ff, power_max_in;
   logic              algorithm_on_ff, algorithm_on_in;
   logic              deadline_mode_ff, deadline_mode_in;
   logic [LVL_W-1:0]  buffer_length_ff, buffer_length_in;
   logic [BAND_W-1:0] band_ff, band_in;
   logic              wr;
   logic              len_wr;
   logic [LVL_W-1:0]  wdata_len;
   logic [LVL_W+23:0] band_prod;

   assign csr_bus.ready = 1'b1;
   assign wr            = csr_bus.valid;
   assign wdata_len     = csr_bus.wdata[LVL_W-1:0];
   assign band_prod     = (LVL_W+24)'(wdata_len) * (LVL_W+24)'(DIV10_RECIP);
   assign len_wr        = wr && (csr_bus.index == REG_BUFFER_LENGTH);

   always_comb begin
      power_min_in     = power_min_ff;
      power_max_in     = power_max_ff;
      algorithm_on_in  = algorithm_on_ff;
      deadline_mode_in = deadline_mode_ff;
      buffer_length_in = buffer_length_ff;
      band_in          = band_ff;
      if (wr) begin
         case (csr_bus.index)
            REG_POWER_MIN:     power_min_in     = csr_bus.wdata[PWR_W-1:0];
            REG_POWER_MAX:     power_max_in     = csr_bus.wdata[PWR_W-1:0];
            REG_ALGORITHM_ON:  algorithm_on_in  = csr_bus.wdata[0];
            REG_DEADLINE_MODE: deadline_mode_in = csr_bus.wdata[0];
            REG_BUFFER_LENGTH: begin
               buffer_length_in = wdata_len;
               band_in          = band_prod[DIV10_SHIFT +: BAND_W];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_min_ff     <= '0;
         power_max_ff     <= '0;
         algorithm_on_ff  <= 1'b0;
         deadline_mode_ff <= 1'b0;
         buffer_length_ff <= LVL_W'(1);
         band_ff          <= '0;
      end else begin
         power_min_ff     <= power_min_in;
         power_max_ff     <= power_max_in;
         algorithm_on_ff  <= algorithm_on_in;
         deadline_mode_ff <= deadline_mode_in;
         buffer_length_ff <= buffer_length_in;
         band_ff          <= band_in;
      end
   end

   assign cfg.power_min     = power_min_ff;
   assign cfg.power_max     = power_max_ff;
   assign cfg.algorithm_on  = algorithm_on_ff;
   assign cfg.deadline_mode = deadline_mode_ff;
   assign cfg.buffer_length = buffer_length_ff;
   assign cfg.band          = band_ff;
   assign cfg.level_load    = len_wr;
   assign cfg.level_value   = {1'b0, wdata_len[LVL_W-1:1]};

endmodule

FILE: src/fdps_dp.sv
// Datapath: hysteresis, droop product, serial step divider, clamp, rounding, output register.
// Depends on fdps_pkg, fdps_req_if and fdps_rsp_if.
module fdps_dp import fdps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  cmd_type     cmd,
   output status_type  status,
   fdps_req_if.sink    req_bus,
   fdps_rsp_if.source  rsp_bus
);

   logic [FREQ_W-1:0] prev_ff, prev_in;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic [FREQ_W-1:0] used_ff, used_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              step_ff, step_in;
   logic              sub_ff, sub_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [RND_W-1:0]  rnd_ff, rnd_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SET_W-1:0]  set_ff, set_in;
   logic [FREQ_W-1:0] echo_ff, echo_in;
   logic              alg_out_ff, alg_out_in;

   logic [FREQ_W-1:0]        f_delta;
   logic signed [DIFF_W-1:0] diff_s;
   logic signed [DF_W-1:0]   df_s;
   logic signed [PROD_W-1:0] prod_s;
   logic [DIFF_W-1:0]        sum_mm;
   logic [PWR_W-1:0]         abs_diff;
   logic [LVL_W-1:0]         len_minus_band;
   logic                     upper, lower;
   logic [FACT_W-1:0]        factor;
   logic [REM_W:0]           rem_sh, rem_sub;
   logic                     q_bit;
   logic [ACC_W-1:0]         q_ext, q60;
   logic signed [ACC_W-1:0]  step_term, hi_s, lo_s, c1, c2;
   logic [RND_W-1:0]         hi_u, lo_u;
   logic [RND_W+16:0]        div6_prod;

   assign f_delta  = (req_bus.frequency_mhz > prev_ff) ? req_bus.frequency_mhz - prev_ff
                                                      : prev_ff - req_bus.frequency_mhz;
   assign diff_s   = $signed({1'b0, cfg.power_max}) - $signed({1'b0, cfg.power_min});
   assign df_s     = $signed({1'b0, used_ff}) - $signed({1'b0, NOMINAL_MHZ});
   assign prod_s   = PROD_W'(diff_s) * PROD_W'(df_s);
   assign sum_mm   = {1'b0, cfg.power_max} + {1'b0, cfg.power_min};
   assign abs_diff = (cfg.power_max >= cfg.power_min) ? cfg.power_max - cfg.power_min
                                                      : cfg.power_min - cfg.power_max;
   assign len_minus_band = cfg.buffer_length - LVL_W'(cfg.band);
   assign upper    = level_ff > len_minus_band;
   assign lower    = level_ff < LVL_W'(cfg.band);
   assign factor   = upper ? {1'b0, level_ff} - {1'b0, len_minus_band}
                           : FACT_W'(cfg.band) - {1'b0, level_ff};

   assign rem_sh   = {rem_ff, num_ff[NUM_W-1]};
   assign q_bit    = rem_sh >= (REM_W+1)'(cfg.band);
   assign rem_sub  = rem_sh - (REM_W+1)'(cfg.band);

   assign q_ext     = ACC_W'(num_ff);
   assign q60       = (q_ext << 6) - (q_ext << 2);
   assign step_term = !step_ff ? '0 : (sub_ff ? -$signed(q60) : $signed(q60));

   assign hi_u      = RND_W'(cfg.power_max) * RND_W'(60);
   assign lo_u      = RND_W'(cfg.power_min) * RND_W'(60);
   assign hi_s      = $signed(ACC_W'(hi_u));
   assign lo_s      = $signed(ACC_W'(lo_u));
   assign c1        = (acc_ff > hi_s) ? hi_s : acc_ff;
   assign c2        = (c1 < lo_s) ? lo_s : c1;

   assign div6_prod = (RND_W+17)'(rnd_ff) * (RND_W+17)'(DIV6_RECIP);

   always_comb begin
      prev_in      = prev_ff;
      level_in     = level_ff;
      freq_in      = freq_ff;
      used_in      = used_ff;
      prod_in      = prod_ff;
      base_in      = base_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      sub_in       = sub_ff;
      acc_in       = acc_ff;
      rnd_in       = rnd_ff;
      set_in       = set_ff;
      echo_in      = echo_ff;
      alg_out_in   = alg_out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      if (cfg.level_load) begin
         level_in = cfg.level_value;
      end
      if (cmd.take) begin
         if (req_bus.req_type) begin
            level_in = req_bus.frames_buffered;
         end else begin
            freq_in = req_bus.frequency_mhz;
            used_in = (f_delta > FREQ_W'(1)) ? req_bus.frequency_mhz : prev_ff;
            if (cfg.algorithm_on) begin
               prev_in = req_bus.frequency_mhz;
            end
         end
      end
      if (cmd.mul) begin
         prod_in = prod_s;
         base_in = BASE_W'(sum_mm) * BASE_W'(30);
         num_in  = NUM_W'(factor) * NUM_W'(abs_diff);
         rem_in  = '0;
         cnt_in  = '0;
         step_in = cfg.deadline_mode && (cfg.band != '0) && (upper || lower);
         sub_in  = upper ^ diff_s[DIFF_W-1];
      end
      if (cmd.div_step) begin
         rem_in = q_bit ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
         num_in = {num_ff[NUM_W-2:0], q_bit};
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.sum) begin
         acc_in = ACC_W'(prod_ff) + $signed(ACC_W'(base_ff)) + step_term;
      end
      if (cmd.clamp) begin
         rnd_in = c2[RND_W-1:0] + RND_W'(3);
      end
      if (cmd.finish) begin
         set_in       = cfg.algorithm_on ? div6_prod[DIV6_SHIFT +: SET_W] : '0;
         echo_in      = freq_ff;
         alg_out_in   = cfg.algorithm_on;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= NOMINAL_MHZ;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      freq_ff    <= freq_in;
      used_ff    <= used_in;
      prod_ff    <= prod_in;
      base_ff    <= base_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      step_ff    <= step_in;
      sub_ff     <= sub_in;
      acc_ff     <= acc_in;
      rnd_ff     <= rnd_in;
      set_ff     <= set_in;
      echo_ff    <= echo_in;
      alg_out_ff <= alg_out_in;
   end

   assign status.alg_on   = cfg.algorithm_on;
   assign status.step_en  = step_ff;
   assign status.div_last = cnt_ff == DIV_LAST;
   assign status.out_free = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.setpoint_tenths = set_ff;
   assign rsp_bus.frequency_echo  = echo_ff;
   assign rsp_bus.setpoint_valid  = alg_out_ff;

endmodule

FILE: src/fdps_ctrl.sv
// Controller state machine sequencing the datapath for one request at a time.
// Depends on fdps_pkg.
module fdps_ctrl import fdps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_is_level,
   input  status_type  status,
   output logic        req_ready,
   output cmd_type     cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (!req_is_level) begin
                  state_in = status.alg_on ? S_MUL : S_FIN;
               end
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!status.step_en) begin
               state_in = S_SUM;
            end else begin
               cmd.div_step = 1'b1;
               if (status.div_last) begin
                  state_in = S_SUM;
               end
            end
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/freq_droop_power_setpoint.sv
// Droop power setpoint from grid-frequency reports; top level of controller and datapath.
// Buffer-level update: loaded in IDLE, no response. Report, algorithm off: straight to FIN.
// Report, algorithm on: MUL, DIV, SUM, CLAMP, FIN; DIV runs the 31-step serial divide by band
// only with a deadline step. One request in flight; FIN waits for a free output, then IDLE.
// Synchronous active-high reset: config to defaults, previous frequency 60000, level 0.
// Depends on fdps_pkg, fdps_if, fdps_regs, fdps_dp, fdps_ctrl and the assert header.
`include "freq_droop_power_setpoint_assert.svh"
module freq_droop_power_setpoint import fdps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   fdps_req_if.sink    req_bus,
   fdps_rsp_if.source  rsp_bus,
   fdps_csr_if.sink    csr_bus
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   fdps_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   fdps_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .cmd     (cmd),
      .status  (status),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   fdps_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_bus.valid),
      .req_is_level (req_bus.req_type),
      .status       (status),
      .req_ready    (req_bus.ready),
      .cmd          (cmd)
   );

   `FDPS_ASSERT_NEXT(a_level_no_rsp, req_bus.valid && req_bus.ready && req_bus.req_type, !$rose(rsp_bus.valid))
   `FDPS_ASSERT_NEXT(a_report_busy, req_bus.valid && req_bus.ready && !req_bus.req_type, !req_bus.ready)
   `FDPS_ASSERT_NOW(a_off_zero, rsp_bus.valid && !rsp_bus.setpoint_valid, rsp_bus.setpoint_tenths == '0)
   `FDPS_ASSERT_NOW(a_within_max, rsp_bus.valid && rsp_bus.setpoint_valid && (cfg.power_min <= cfg.power_max), rsp_bus.setpoint_tenths <= SET_W'(cfg.power_max) * SET_W'(10))

endmodule
